// File: rtl/core/mor_pkg.sv
// Package for the masked overlap RMSE block: payload structs, the command and
// status structs between controller and datapath, and sizing constants.
// No dependencies.
package mor_pkg;

   localparam int MAX_PIXELS = 4194304;

   localparam int PIXEL_W = 8;
   localparam int SQ_W    = 2 * PIXEL_W;
   localparam int SUM_W   = 38;
   localparam int TALLY_W = 23;
   localparam int RMSE_W  = 16;

   // Quotient of (sum << 16) / count is below 2^32, its root below 2^16.
   localparam int QUOT_W     = 32;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int SQRT_STEPS = QUOT_W / 2;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int SREM_W     = RMSE_W + 2;

   localparam longint TALLY_FIELD_MAX = (64'd1 << TALLY_W) - 1;
   localparam logic [TALLY_W-1:0] TALLY_CAP =
      TALLY_W'((MAX_PIXELS < TALLY_FIELD_MAX) ? MAX_PIXELS : TALLY_FIELD_MAX);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_a;
      logic [PIXEL_W-1:0] pixel_b;
      logic               mask_a;
      logic               mask_b;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic               overlap_bit;
      logic               result_valid;
      logic [RMSE_W-1:0]  rmse_q8;
      logic [TALLY_W-1:0] overlap_count;
      logic               no_overlap;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic accum;           // accepted pixel: accumulate it
      logic load_pixel_rsp;  // load a per-pixel result
      logic div_load;        // seed divider and root registers
      logic div_step;        // one restoring division step
      logic sqrt_step;       // one square root digit
      logic load_frame_rsp;  // load the frame result and clear the frame state
   } cmd_type;

   typedef struct packed {
      logic count_zero;
   } status_type;

endpackage

// File: rtl/core/masked_overlap_rmse.sv
// Masked overlap RMSE, top level. A pixel that does not end the frame gives its
// result in the cycle after its transfer; a new pixel is taken every cycle while
// the result register is free. The frame's last pixel runs a seed step, 32 serial
// division steps, 16 root digit steps and a load step that waits for a free result
// register; no pixel is taken meanwhile. With no overlap division and root are skipped.
// Synchronous active-high reset clears the accumulators and the result valid flag.
module masked_overlap_rmse
   import mor_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   mor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .frame_end (req_data.frame_end),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mor_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/core/mor_datapath.sv
// Datapath of the masked overlap RMSE block: accumulators, a shared
// shift register for the serial divider and square root, and the result register.
// Depends on mor_pkg.
module mor_datapath
   import mor_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               sat_ff, sat_in;
   logic               last_ovl_ff, last_ovl_in;

   logic [QUOT_W-1:0]  work_ff, work_in;
   logic [TALLY_W-1:0] rem_ff, rem_in;
   logic [SREM_W-1:0]  srem_ff, srem_in;
   logic [RMSE_W-1:0]  root_ff, root_in;
   rsp_type            rsp_ff, rsp_in;

   logic               overlap;
   logic [PIXEL_W-1:0] diff;
   logic [SQ_W-1:0]    square;
   logic [SUM_W:0]     sum_plus;
   logic               sat_hit;

   logic [TALLY_W:0]   div_trial;
   logic               div_ge;
   logic [SREM_W+1:0]  sq_trial;
   logic [SREM_W+1:0]  sq_sub;
   logic               sq_ge;

   assign overlap  = req_data.mask_a & req_data.mask_b;
   assign diff     = (req_data.pixel_a >= req_data.pixel_b) ?
                     (req_data.pixel_a - req_data.pixel_b) :
                     (req_data.pixel_b - req_data.pixel_a);
   assign square   = diff * diff;
   assign sum_plus = {1'b0, sum_ff} + (SUM_W+1)'(square);
   assign sat_hit  = (tally_ff >= TALLY_CAP) || sum_plus[SUM_W];

   // The running remainder stays below the count, so the trial never needs
   // more than one bit above it.
   assign div_trial = {rem_ff, work_ff[QUOT_W-1]};
   assign div_ge    = div_trial >= {1'b0, tally_ff};

   assign sq_trial = {srem_ff, work_ff[QUOT_W-1 -: 2]};
   assign sq_sub   = (SREM_W+2)'({root_ff, 2'b01});
   assign sq_ge    = sq_trial >= sq_sub;

   assign status.count_zero = (tally_ff == '0);

   always_comb begin
      sum_in      = sum_ff;
      tally_in    = tally_ff;
      sat_in      = sat_ff;
      last_ovl_in = last_ovl_ff;
      work_in     = work_ff;
      rem_in      = rem_ff;
      srem_in     = srem_ff;
      root_in     = root_ff;
      rsp_in      = rsp_ff;

      if (cmd.accum) begin
         last_ovl_in = overlap;
         if (overlap) begin
            if (sat_hit) begin
               sat_in = 1'b1;
            end else begin
               sum_in   = sum_plus[SUM_W-1:0];
               tally_in = tally_ff + 1'b1;
            end
         end
      end

      if (cmd.load_pixel_rsp) begin
         rsp_in             = '0;
         rsp_in.overlap_bit = overlap;
      end

      if (cmd.div_load) begin
         work_in = {sum_ff[QUOT_W/2-1:0], {(QUOT_W/2){1'b0}}};
         rem_in  = TALLY_W'(sum_ff[SUM_W-1:QUOT_W/2]);
         srem_in = '0;
         root_in = '0;
      end

      if (cmd.div_step) begin
         rem_in  = div_ge ? TALLY_W'(div_trial - {1'b0, tally_ff}) : div_trial[TALLY_W-1:0];
         work_in = {work_ff[QUOT_W-2:0], div_ge};
      end

      if (cmd.sqrt_step) begin
         srem_in = sq_ge ? SREM_W'(sq_trial - sq_sub) : sq_trial[SREM_W-1:0];
         root_in = {root_ff[RMSE_W-2:0], sq_ge};
         work_in = {work_ff[QUOT_W-3:0], 2'b00};
      end

      if (cmd.load_frame_rsp) begin
         rsp_in.overlap_bit   = last_ovl_ff;
         rsp_in.result_valid  = 1'b1;
         rsp_in.rmse_q8       = root_ff;
         rsp_in.overlap_count = tally_ff;
         rsp_in.no_overlap    = status.count_zero;
         rsp_in.overflow      = sat_ff;
         sum_in               = '0;
         tally_in             = '0;
         sat_in               = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         tally_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         tally_ff <= tally_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ovl_ff <= last_ovl_in;
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/core/mor_ctrl.sv
// Controller of the masked overlap RMSE block: handshakes, the frame-end
// sequence through division and square root, and the result valid flag.
// Depends on mor_pkg.
module mor_ctrl
   import mor_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       frame_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SQRT   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              req_xfer;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd.accum = 1'b1;
               if (frame_end) begin
                  state_in = ST_PREP;
               end else begin
                  cmd.load_pixel_rsp = 1'b1;
               end
            end
         end
         ST_PREP: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = status.count_zero ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_frame_rsp = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_pixel_rsp || cmd.load_frame_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never loaded over one that has not been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_pixel_rsp || cmd.load_frame_rsp) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   a_frame_end_seq: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && frame_end) |=> (state_ff == ST_PREP))
      else $error("frame end did not start the metric sequence");

   a_div_to_sqrt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == STEP_W'(DIV_STEPS - 1)) |=>
      (state_ff == ST_SQRT && step_ff == '0))
      else $error("division did not hand over to the square root");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accum, cmd.div_load, cmd.div_step, cmd.sqrt_step, cmd.load_frame_rsp}))
      else $error("conflicting datapath commands");

endmodule
